>>> rtl/ppm_p6_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// PPM P6 stream decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PPM_P6_STREAM_DECODER_ASSERT_SVH
`define PPM_P6_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define PP6D_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PP6D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pp6d_pkg.sv
// ----------------------------------------------------------------------------
// pp6d_pkg
// Types and constants shared by the PPM P6 decoder controller and datapath.
// ----------------------------------------------------------------------------
package pp6d_pkg;

  // result kind, carried on the output tuser
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // characters of the header syntax
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // scale coefficient is COEF_NUM / maximum
  localparam logic [7:0] COEF_NUM = 8'hFF;

  // pixel counter width
  localparam int unsigned PIX_CNT_W = 32;

  // controller -> datapath commands
  typedef struct packed {
    logic  acc_load;   // start a number with the current digit
    logic  acc_accum;  // append the current digit
    logic  latch_w;    // width <= clamped number
    logic  latch_h;    // height <= clamped number
    logic  hdr_start;  // start pixel count product and coefficient divide
    logic  pix_byte;   // take one color component
    logic  emit;       // load the output register
    kind_e kind;       // kind of the emitted result
  } ctrl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic       is_hash;
    logic       is_eol;
    logic       is_p;
    logic       is_six;
    logic       acc_zero;
    logic       acc_gt_max;  // number above 255
    logic       div_done;
    logic       count_zero;  // width times height is zero
    logic       pix_last;    // one pixel left
    logic [1:0] comp_idx;
  } dp_status_t;

endpackage

>>> rtl/pp6d_div.sv
// ----------------------------------------------------------------------------
// pp6d_div
// Restoring divider for the scale coefficient 255 / maximum, one bit a cycle.
// ----------------------------------------------------------------------------
module pp6d_div import pp6d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] divisor_i,
  output logic       done_o,
  output logic [7:0] quot_o
);

  localparam int unsigned Steps = 8;
  localparam int unsigned CntW  = $clog2(Steps);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [7:0]      div_q;
  logic [7:0]      rem_q;
  logic [7:0]      quo_q;
  logic [8:0]      trial;
  logic [8:0]      diff;
  logic            fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[7]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // remainder and quotient; quotient register starts as the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= COEF_NUM;
    end else if (busy_q) begin
      rem_q <= fits ? diff[7:0] : trial[7:0];
      quo_q <= {quo_q[6:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/pp6d_datapath.sv
// ----------------------------------------------------------------------------
// pp6d_datapath
// Byte classes, number accumulator, size registers, pixel scaling and the
// output word register of the PPM P6 decoder.
// ----------------------------------------------------------------------------
module pp6d_datapath import pp6d_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  sts_o,
  output kind_e       kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        last_pixel_o
);

  localparam int unsigned AccW = DIM_BITS + 1;
  localparam int unsigned MulW = DIM_BITS + 5;
  localparam int unsigned ProdW = (2 * DIM_BITS > PIX_CNT_W) ? 2 * DIM_BITS : PIX_CNT_W + 1;
  localparam logic [AccW-1:0] AccCap = {1'b1, {DIM_BITS{1'b0}}};

  logic [AccW-1:0]      acc_q;
  logic [DIM_BITS-1:0]  w_q;
  logic [DIM_BITS-1:0]  h_q;
  logic [ProdW-1:0]     prod_q;
  logic [PIX_CNT_W-1:0] count_q;
  logic [PIX_CNT_W-1:0] count_sat;
  logic [7:0]           coef_q;
  logic [1:0]           comp_q;
  logic [7:0]           red_hold_q;
  logic [7:0]           green_hold_q;
  logic [3:0]           digit;
  logic [MulW-1:0]      acc_next;
  logic [DIM_BITS-1:0]  acc_clamp;
  logic                 div_done;
  logic [7:0]           div_quot;
  logic [7:0]           red_mul;
  logic [7:0]           green_mul;
  logic [7:0]           blue_mul;

  kind_e                kind_q;
  logic [7:0]           red_q;
  logic [7:0]           green_q;
  logic [7:0]           blue_q;
  logic [15:0]          owidth_q;
  logic [15:0]          oheight_q;
  logic                 last_q;

  // byte classes
  assign digit = 4'(data_byte_i - CH_ZERO);

  always_comb begin
    sts_o.is_space   = data_byte_i inside {CH_SPACE, [CH_TAB:CH_CR]};
    sts_o.is_digit   = data_byte_i inside {[CH_ZERO:CH_NINE]};
    sts_o.is_hash    = data_byte_i == CH_HASH;
    sts_o.is_eol     = data_byte_i inside {CH_LF, CH_CR};
    sts_o.is_p       = data_byte_i == CH_P;
    sts_o.is_six     = data_byte_i == CH_SIX;
    sts_o.acc_zero   = acc_q == '0;
    sts_o.acc_gt_max = |acc_q[AccW-1:8];
    sts_o.div_done   = div_done;
    sts_o.count_zero = prod_q == '0;
    sts_o.pix_last   = count_q == PIX_CNT_W'(1);
    sts_o.comp_idx   = comp_q;
  end

  // decimal accumulate, saturating at 2^DIM_BITS
  always_comb begin
    acc_next = (MulW'(acc_q) << 3) + (MulW'(acc_q) << 1) + MulW'(digit);
    if (acc_next > MulW'(AccCap)) begin
      acc_next = MulW'(AccCap);
    end
  end

  assign acc_clamp = acc_q[DIM_BITS] ? '1 : acc_q[DIM_BITS-1:0];
  assign count_sat = (|prod_q[ProdW-1:PIX_CNT_W]) ? '1 : prod_q[PIX_CNT_W-1:0];

  // number and size registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      acc_q <= AccW'(digit);
    end else if (cmd_i.acc_accum) begin
      acc_q <= acc_next[AccW-1:0];
    end
    if (cmd_i.latch_w) begin
      w_q <= acc_clamp;
    end
    if (cmd_i.latch_h) begin
      h_q <= acc_clamp;
    end
    if (cmd_i.hdr_start) begin
      prod_q <= ProdW'(w_q) * ProdW'(h_q);
    end
  end

  // coefficient divider
  pp6d_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.hdr_start),
    .divisor_i (acc_q[7:0]),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // pixel assembly and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= '0;
    end else if (cmd_i.emit && cmd_i.kind == KIND_HEADER) begin
      comp_q <= '0;
    end else if (cmd_i.pix_byte) begin
      comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && cmd_i.kind == KIND_HEADER) begin
      coef_q  <= div_quot;
      count_q <= count_sat;
    end else if (cmd_i.pix_byte) begin
      case (comp_q)
        2'd0:    red_hold_q   <= data_byte_i;
        2'd1:    green_hold_q <= data_byte_i;
        default: count_q      <= count_q - PIX_CNT_W'(1);
      endcase
    end
  end

  // scaled components, truncated to 8 bits
  assign red_mul   = red_hold_q * coef_q;
  assign green_mul = green_hold_q * coef_q;
  assign blue_mul  = data_byte_i * coef_q;

  // output word register; fields that do not belong to the kind read zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      case (cmd_i.kind)
        KIND_PIXEL: begin
          red_q     <= red_mul;
          green_q   <= green_mul;
          blue_q    <= blue_mul;
          owidth_q  <= '0;
          oheight_q <= '0;
          last_q    <= count_q == PIX_CNT_W'(1);
        end
        KIND_HEADER: begin
          red_q     <= '0;
          green_q   <= '0;
          blue_q    <= '0;
          owidth_q  <= 16'(w_q);
          oheight_q <= 16'(h_q);
          last_q    <= 1'b0;
        end
        default: begin
          red_q     <= '0;
          green_q   <= '0;
          blue_q    <= '0;
          owidth_q  <= '0;
          oheight_q <= '0;
          last_q    <= 1'b0;
        end
      endcase
    end
  end

  assign kind_o         = kind_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign image_width_o  = owidth_q;
  assign image_height_o = oheight_q;
  assign last_pixel_o   = last_q;

endmodule

>>> rtl/pp6d_ctrl.sv
// ----------------------------------------------------------------------------
// pp6d_ctrl
// Parse state machine and stream handshake of the PPM P6 decoder.
// ----------------------------------------------------------------------------
`include "ppm_p6_stream_decoder_assert.svh"

module pp6d_ctrl import pp6d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic       s_start_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] PH_MAGIC_P  = 4'd0;
  localparam logic [3:0] PH_MAGIC_6  = 4'd1;
  localparam logic [3:0] PH_PRE_W    = 4'd2;
  localparam logic [3:0] PH_COM_W    = 4'd3;
  localparam logic [3:0] PH_NUM_W    = 4'd4;
  localparam logic [3:0] PH_PRE_H    = 4'd5;
  localparam logic [3:0] PH_COM_H    = 4'd6;
  localparam logic [3:0] PH_NUM_H    = 4'd7;
  localparam logic [3:0] PH_PRE_M    = 4'd8;
  localparam logic [3:0] PH_COM_M    = 4'd9;
  localparam logic [3:0] PH_NUM_M    = 4'd10;
  localparam logic [3:0] PH_PIXELS   = 4'd11;
  localparam logic [3:0] PH_IDLE     = 4'd12;
  localparam logic [3:0] PH_HDR_CALC = 4'd13;

  typedef struct packed {
    logic       err;
    logic       load;
    logic [3:0] phase;
  } pre_t;

  logic [3:0] phase_q;
  logic [3:0] phase_d;
  logic [3:0] ph;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       slot_free;
  logic       in_acc;
  logic       err;
  pre_t       pre_r;

  // skip phase before a number: whitespace stays, '#' opens a comment
  function automatic pre_t pre_step(input dp_status_t s, input logic [3:0] cur,
                                    input logic [3:0] com, input logic [3:0] num);
    pre_t r;
    r.err   = 1'b0;
    r.load  = 1'b0;
    r.phase = cur;
    if (s.is_hash) begin
      r.phase = com;
    end else if (s.is_digit) begin
      r.load  = 1'b1;
      r.phase = num;
    end else if (!s.is_space) begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  // handshake
  assign slot_free = !out_valid_q || m_ready_i;
  assign s_ready_o = (phase_q != PH_HDR_CALC) && slot_free;
  assign in_acc    = s_valid_i && s_ready_o;
  assign ph        = s_start_i ? PH_MAGIC_P : phase_q;

  // next phase and commands
  always_comb begin
    phase_d = phase_q;
    cmd_o   = '0;
    err     = 1'b0;
    pre_r   = '0;
    if (phase_q == PH_HDR_CALC) begin
      if (sts_i.div_done && slot_free) begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = KIND_HEADER;
        phase_d    = sts_i.count_zero ? PH_IDLE : PH_PIXELS;
      end
    end else if (in_acc) begin
      phase_d = ph;
      case (ph)
        PH_MAGIC_P: begin
          if (sts_i.is_p) phase_d = PH_MAGIC_6;
          else            err     = 1'b1;
        end
        PH_MAGIC_6: begin
          if (sts_i.is_six) phase_d = PH_PRE_W;
          else              err     = 1'b1;
        end
        PH_PRE_W, PH_PRE_H, PH_PRE_M: begin
          pre_r          = pre_step(sts_i, ph, ph + 4'd1, ph + 4'd2);
          phase_d        = pre_r.phase;
          cmd_o.acc_load = pre_r.load;
          err            = pre_r.err;
        end
        PH_COM_W, PH_COM_H, PH_COM_M: begin
          if (sts_i.is_eol) phase_d = ph - 4'd1;
        end
        PH_NUM_W, PH_NUM_H: begin
          if (sts_i.is_digit) begin
            cmd_o.acc_accum = 1'b1;
          end else begin
            // terminator byte opens the skip before the next number
            cmd_o.latch_w  = ph == PH_NUM_W;
            cmd_o.latch_h  = ph == PH_NUM_H;
            pre_r          = pre_step(sts_i, ph + 4'd1, ph + 4'd2, ph + 4'd3);
            phase_d        = pre_r.phase;
            cmd_o.acc_load = pre_r.load;
            err            = pre_r.err;
          end
        end
        PH_NUM_M: begin
          if (sts_i.is_digit) begin
            cmd_o.acc_accum = 1'b1;
          end else if (sts_i.acc_zero || sts_i.acc_gt_max) begin
            err = 1'b1;
          end else begin
            cmd_o.hdr_start = 1'b1;
            phase_d         = PH_HDR_CALC;
          end
        end
        PH_PIXELS: begin
          cmd_o.pix_byte = 1'b1;
          if (sts_i.comp_idx == 2'd2) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_PIXEL;
            if (sts_i.pix_last) phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      if (err) begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = KIND_ERROR;
        phase_d    = PH_IDLE;
      end
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC_P;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

  // checks
  `PP6D_ASSERT(a_no_input_in_calc, phase_q == PH_HDR_CALC, !in_acc, "byte taken during header calc")
  `PP6D_ASSERT(a_no_overwrite, out_valid_q && !m_ready_i, !cmd_o.emit, "pending word overwritten")
  `PP6D_ASSERT_NEXT(a_hdr_emitted, phase_q == PH_HDR_CALC && sts_i.div_done && slot_free, out_valid_q && phase_q != PH_HDR_CALC, "header not emitted")
  `PP6D_ASSERT(a_comp_range, phase_q == PH_PIXELS, sts_i.comp_idx != 2'd3, "component index out of range")

endmodule

>>> rtl/ppm_p6_stream_decoder.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder
// Binary PPM (P6) parser: header check, size report and scaled pixel output.
// ----------------------------------------------------------------------------
// Input stream: one file byte per word on s_axis_tdata; s_axis_tuser set on
// the first byte of a file restarts the parser before that byte is taken.
// Output stream: one word per header, format error or pixel; tuser gives the
// kind (pixel, header, error) and tlast marks the final pixel of an image.
// Header and pixel bytes are taken at one byte per cycle. Pixel and error
// words are registered and appear in the cycle after the byte that completes
// them. The byte that ends the maximum value starts a multiply for the pixel
// count and an 8-step restoring divide for the 255 / maximum coefficient;
// the header word is emitted once the divide is done and the output register
// is free, and the input is held off until then.
// A stalled receiver holds the output word; the input takes a new byte only
// while the output register is empty or being drained the same cycle.
// Reset returns the parser to expecting the 'P' of the magic with no word
// pending. After an error or the last pixel, bytes are dropped until a new
// file start.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder import pp6d_pkg::*; #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] file_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                      // [39:24] image_width, [55:40] image_height
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_pixel
);

  ctrl_cmd_t   cmd;
  dp_status_t  sts;
  kind_e       kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        last_pixel;

  pp6d_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_start_i (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pp6d_datapath #(
    .DIM_BITS (DIM_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_o         (kind),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .image_width_o  (image_width),
    .image_height_o (image_height),
    .last_pixel_o   (last_pixel)
  );

  // output word packing
  assign m_axis_tdata = {image_height, image_width, blue, green, red};
  assign m_axis_tuser = kind;
  assign m_axis_tlast = last_pixel;

endmodule

>>> tb/ppm_p6_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_p6_decode_checker
// Watches both stream channels of the PPM P6 decoder. Every byte accepted on
// the input runs through a local parser that works out the header, error or
// pixel word it should produce. Those words wait in order until an output
// word is accepted, and then each field is compared with the oldest one.
// ----------------------------------------------------------------------------
module ppm_p6_decode_checker import pp6d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  input  logic [7:0]  in_tdata_i,    // [7:0] data_byte
  input  logic        in_tuser_i,    // [0] file_start
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  input  logic [55:0] out_tdata_i,   // [7:0] red, [15:8] green, [23:16] blue,
                                     // [39:24] image_width, [55:40] image_height
  input  logic [1:0]  out_tuser_i,   // [1:0] kind
  input  logic        out_tlast_i,   // last_pixel
  output int          mismatches_o,
  output int          pending_o
);

  localparam int unsigned DIM_BITS = 16;
  localparam int unsigned DIM_MAX  = (1 << DIM_BITS) - 1;
  localparam int unsigned ACC_CAP  = 1 << DIM_BITS;
  localparam int unsigned MAX_SHOWN = 10;

  typedef enum logic [3:0] {
    SEEK_P, SEEK_SIX,
    GAP_W, NOTE_W, DIGITS_W,
    GAP_H, NOTE_H, DIGITS_H,
    GAP_M, NOTE_M, DIGITS_M,
    PIXELS, IDLE
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] width;
    logic [15:0] height;
    logic        last_pixel;
  } word_t;

  // parser state
  phase_e      phase;
  logic [16:0] accum;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [7:0]  coef;
  logic [31:0] pix_left;
  logic [1:0]  comp;
  logic [7:0]  red_q;
  logic [7:0]  green_q;

  word_t expected_words[$];

  function automatic void clear_parser();
    phase    = SEEK_P;
    accum    = '0;
    width_q  = '0;
    height_q = '0;
    coef     = '0;
    pix_left = '0;
    comp     = '0;
    red_q    = '0;
    green_q  = '0;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_numeral(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // skip ahead of a number; 1 means format error
  function automatic bit gap_byte(logic [7:0] b, phase_e note_ph, phase_e digit_ph);
    if (is_blank(b)) return 1'b0;
    if (b == CH_HASH) begin
      phase = note_ph;
      return 1'b0;
    end
    if (is_numeral(b)) begin
      accum = 17'(b - CH_ZERO);
      phase = digit_ph;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // comment runs to CR or LF
  function automatic void note_byte(logic [7:0] b, phase_e gap_ph);
    if (b == CH_LF || b == CH_CR) phase = gap_ph;
  endfunction

  // decimal accumulate, saturating at 2^DIM_BITS
  function automatic void add_digit(logic [7:0] b);
    int unsigned v;
    v = 32'(accum) * 10 + 32'(b - CH_ZERO);
    accum = (v > ACC_CAP) ? 17'(ACC_CAP) : 17'(v);
  endfunction

  function automatic logic [15:0] clamp_dim();
    return (32'(accum) > DIM_MAX) ? 16'(DIM_MAX) : accum[15:0];
  endfunction

  // one input byte; returns 1 when it produces a word
  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output word_t res);
    bit bad;
    logic [63:0] area;
    bad = 1'b0;
    res = '0;
    if (start) clear_parser();
    case (phase)
      SEEK_P: begin
        if (b == CH_P) phase = SEEK_SIX;
        else bad = 1'b1;
      end
      SEEK_SIX: begin
        if (b == CH_SIX) phase = GAP_W;
        else bad = 1'b1;
      end
      GAP_W:  bad = gap_byte(b, NOTE_W, DIGITS_W);
      NOTE_W: note_byte(b, GAP_W);
      DIGITS_W: begin
        if (is_numeral(b)) begin
          add_digit(b);
        end else begin
          width_q = clamp_dim();
          phase = GAP_H;
          bad = gap_byte(b, NOTE_H, DIGITS_H);
        end
      end
      GAP_H:  bad = gap_byte(b, NOTE_H, DIGITS_H);
      NOTE_H: note_byte(b, GAP_H);
      DIGITS_H: begin
        if (is_numeral(b)) begin
          add_digit(b);
        end else begin
          height_q = clamp_dim();
          phase = GAP_M;
          bad = gap_byte(b, NOTE_M, DIGITS_M);
        end
      end
      GAP_M:  bad = gap_byte(b, NOTE_M, DIGITS_M);
      NOTE_M: note_byte(b, GAP_M);
      DIGITS_M: begin
        if (is_numeral(b)) begin
          add_digit(b);
        end else if (accum == '0 || accum > 17'd255) begin
          bad = 1'b1;
        end else begin
          // maximum terminator is dropped; header goes out now
          area = 64'(width_q) * 64'(height_q);
          coef = 8'(32'(COEF_NUM) / 32'(accum));
          pix_left = (area > 64'hFFFF_FFFF) ? '1 : area[31:0];
          comp = '0;
          phase = (pix_left != '0) ? PIXELS : IDLE;
          res.kind = KIND_HEADER;
          res.width = width_q;
          res.height = height_q;
          return 1'b1;
        end
      end
      PIXELS: begin
        if (comp == 2'd0) begin
          red_q = b;
          comp = 2'd1;
        end else if (comp == 2'd1) begin
          green_q = b;
          comp = 2'd2;
        end else begin
          comp = 2'd0;
          res.kind = KIND_PIXEL;
          res.red = 8'(red_q * coef);
          res.green = 8'(green_q * coef);
          res.blue = 8'(b * coef);
          pix_left = pix_left - 1;
          if (pix_left == '0) begin
            res.last_pixel = 1'b1;
            phase = IDLE;
          end
          return 1'b1;
        end
      end
      default: phase = IDLE;
    endcase
    if (bad) begin
      width_q = '0;
      height_q = '0;
      phase = IDLE;
      res.kind = KIND_ERROR;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note_failure(string what, word_t want, word_t got);
    mismatches_o++;
    if (mismatches_o <= MAX_SHOWN)
      $display("%0t %s: expected kind=%0d rgb=%0d/%0d/%0d size=%0dx%0d last=%0b, ",
               $time, what, want.kind, want.red, want.green, want.blue,
               want.width, want.height, want.last_pixel,
               "got kind=%0d rgb=%0d/%0d/%0d size=%0dx%0d last=%0b",
               got.kind, got.red, got.green, got.blue,
               got.width, got.height, got.last_pixel);
  endtask

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    word_t want;
    word_t got;
    if (!rst_ni) begin
      clear_parser();
      expected_words.delete();
      mismatches_o = 0;
      pending_o <= 0;
    end else begin
      if (in_tvalid_i && in_tready_i) begin
        if (decode_byte(in_tdata_i, in_tuser_i, want))
          expected_words.push_back(want);
      end
      if (out_tvalid_i && out_tready_i) begin
        got.kind       = kind_e'(out_tuser_i);
        got.red        = out_tdata_i[7:0];
        got.green      = out_tdata_i[15:8];
        got.blue       = out_tdata_i[23:16];
        got.width      = out_tdata_i[39:24];
        got.height     = out_tdata_i[55:40];
        got.last_pixel = out_tlast_i;
        if (expected_words.size() == 0) begin
          note_failure("unexpected word", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.red !== want.red ||
              got.green !== want.green || got.blue !== want.blue ||
              got.width !== want.width || got.height !== want.height ||
              got.last_pixel !== want.last_pixel)
            note_failure("word mismatch", want, got);
        end
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

>>> tb/ppm_p6_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder_tb
// Feeds the PPM P6 decoder whole files: a directed set covering magic errors,
// signs, comments, saturating sizes, bad maximums, empty images and restarts,
// then random files, mostly well formed with random spacing, comments and
// pixel data, the rest corrupted or plain noise. Both stream sides idle at
// random; the checker beside the decoder predicts and compares every word.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder_tb;
  import pp6d_pkg::*;

  localparam int unsigned RANDOM_BYTES  = 320;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam logic [7:0]  CH_VTAB  = 8'h0B;
  localparam logic [7:0]  CH_FEED  = 8'h0C;
  localparam logic [7:0]  CH_MINUS = 8'h2D;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic        quiet = 1'b0;     // no idling on either side while set
  int          mismatches;
  int          pending;
  int unsigned stall_cycles = 0;
  int unsigned random_bytes = 0;
  logic [7:0]  file_bytes[$];

  ppm_p6_stream_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ppm_p6_decode_checker decode_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .out_tuser_i  (m_axis_tuser),
    .out_tlast_i  (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls at random, but never while quiet is set
  always @(negedge clk)
    m_axis_tready <= quiet || ($urandom_range(99) >= 7);

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VTAB;
      4: return CH_FEED;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_non_digit();
    logic [7:0] b;
    do b = 8'($urandom); while (b >= CH_ZERO && b <= CH_NINE);
    return b;
  endfunction

  // whitespace, sometimes with a comment ended by CR or LF
  task automatic push_gap();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) file_bytes.push_back(pick_blank());
    if ($urandom_range(3) == 0) begin
      file_bytes.push_back(CH_HASH);
      repeat ($urandom_range(0, 5)) begin
        do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
        file_bytes.push_back(b);
      end
      file_bytes.push_back($urandom_range(1) ? CH_LF : CH_CR);
      if ($urandom_range(1)) file_bytes.push_back(pick_blank());
    end
  endtask

  task automatic push_number(int unsigned v);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 2)) file_bytes.push_back(CH_ZERO);
    push_text($sformatf("%0d", v));
  endtask

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(65530, 99999);
    return $urandom_range(1, 4);
  endfunction

  function automatic int unsigned pick_max();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 16) return $urandom_range(256, 70000);
    if (r < 24) return 255;
    if (r < 30) return 1;
    return $urandom_range(1, 255);
  endfunction

  // mostly well-formed file, at times with a bad maximum; large images and a few others are cut short
  task automatic build_good_file();
    int unsigned w;
    int unsigned h;
    longint unsigned n;
    w = pick_dim();
    h = pick_dim();
    push_text("P6");
    if ($urandom_range(3) != 0) push_gap();
    push_number(w);
    push_gap();
    push_number(h);
    push_gap();
    push_number(pick_max());
    file_bytes.push_back(($urandom_range(3) == 0) ? pick_non_digit() : pick_blank());
    n = 3 * longint'(w) * longint'(h);
    if (n > 48) n = 3 * $urandom_range(1, 16);
    if (n > 0 && $urandom_range(9) == 0) n = $urandom_range(0, int'(n) - 1);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic build_random_file();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      build_good_file();
    end else if (r < 90) begin
      build_good_file();
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
    end else begin
      if ($urandom_range(1)) file_bytes.push_back(CH_P);
      repeat ($urandom_range(4, 16)) file_bytes.push_back(8'($urandom));
    end
  endtask

  // one byte; sender idles at random before it, but not while quiet is set
  task automatic send_byte(logic [7:0] b, logic start);
    while (!quiet && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // file bytes, then a few trailing bytes the parser should mostly drop
  task automatic send_file(logic with_start, int unsigned trail);
    foreach (file_bytes[i]) send_byte(file_bytes[i], with_start && i == 0);
    repeat (trail) send_byte(8'($urandom), 1'b0);
    file_bytes.delete();
  endtask

  // hold off until every expected word has come out
  task automatic drain_pause();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat ($urandom_range(2, 20)) @(negedge clk);
  endtask

  initial begin
    int unsigned file_no;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // straight after reset, no start flag; coefficient 1, extreme pixels
    push_text("P6 2 1 255\n");
    file_bytes.push_back(8'h00); file_bytes.push_back(8'hFF); file_bytes.push_back(8'h80);
    file_bytes.push_back(8'h7F); file_bytes.push_back(8'h01); file_bytes.push_back(8'hFE);
    send_file(1'b0, 2);
    // comments ended by CR and LF, all whitespace bytes, maximum 1
    push_text("P6#hi\r 3#cm\n1");
    file_bytes.push_back(CH_FEED);
    push_text("\t1");
    file_bytes.push_back(CH_VTAB);
    file_bytes.push_back(8'h01); file_bytes.push_back(8'h00); file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00); file_bytes.push_back(8'h01); file_bytes.push_back(8'h02);
    file_bytes.push_back(8'hFF); file_bytes.push_back(8'hFF); file_bytes.push_back(8'hFF);
    send_file(1'b1, 3);
    // bad first and second magic byte
    push_text("Q6 1 1 255 ");
    send_file(1'b1, 0);
    push_text("P5 1 1 255 ");
    send_file(1'b1, 0);
    // signs and a bad width terminator
    push_text("P6 ");
    file_bytes.push_back(CH_MINUS);
    push_text("3 1 9 ");
    send_file(1'b1, 0);
    push_text("P6 +3 1 9 ");
    send_file(1'b1, 0);
    push_text("P6 3x 2 9 ");
    send_file(1'b1, 0);
    // saturated width with zero height: empty image
    push_text("P699999 0 7 abc");
    send_file(1'b1, 0);
    // bad maximums
    push_text("P6 1 1 0 ");
    send_file(1'b1, 0);
    push_text("P6 1 1 256 ");
    send_file(1'b1, 0);
    // leading zeros, '#' ending the maximum, coefficient 127
    push_text("P6 1 1 00002#");
    file_bytes.push_back(8'h80); file_bytes.push_back(8'hFF); file_bytes.push_back(8'h03);
    send_file(1'b1, 2);
    // restart in the middle of pixels
    push_text("P6 2 2 200\n");
    repeat (4) file_bytes.push_back(8'($urandom));
    send_file(1'b1, 0);
    push_text("P6 1 70000 255 ");
    repeat (7) file_bytes.push_back(8'($urandom));
    send_file(1'b1, 0);
    drain_pause();
    push_text("P6 3 2 100\r");
    repeat (18) file_bytes.push_back(8'($urandom));
    send_file(1'b1, 1);

    // random files
    file_no = 0;
    while (random_bytes < RANDOM_BYTES) begin
      quiet = (file_no >= 6 && file_no < 14);
      if (file_no % 9 == 8) drain_pause();
      build_random_file();
      random_bytes += file_bytes.size();
      send_file(1'b1, $urandom_range(0, 3));
      file_no++;
    end
    quiet = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
